>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the scanner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is off while reset is held
`define WBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// assertion that also holds during reset
`define WBPS_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Types, codes and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // pattern depth default
  localparam int unsigned PATTERN_MAX_DEF = 64;

  // apb address width and register indexes
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_MAX_RESULTS    = 2'd1;
  localparam logic [1:0] REG_MAX_BUDGET     = 2'd2;

  // register reset values
  localparam logic [6:0]  PATTERN_LENGTH_RST = 7'd1;
  localparam logic [31:0] MAX_RESULTS_RST    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_BUDGET_RST     = 32'hFFFF_FFFF;

  // commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_NOMATCH = 3'd0;
  localparam logic [2:0] STAT_MATCH   = 3'd1;
  localparam logic [2:0] STAT_LOADED  = 3'd2;
  localparam logic [2:0] STAT_STARTED = 3'd3;
  localparam logic [2:0] STAT_REFUSED = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  entry_index;
    logic [7:0]  entry_value;
    logic        entry_wildcard;
    logic [63:0] range_base;
    logic        new_scan;
    logic [7:0]  data_byte;
  } wbps_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] match_address;
    logic [31:0] match_count;
    logic [31:0] bytes_scanned;
    logic        result_limit_reached;
    logic        byte_limit_reached;
  } wbps_out_t;

  typedef struct packed {
    logic [6:0]  pattern_length;
    logic [31:0] max_results;
    logic [31:0] max_byte_budget;
  } wbps_cfg_t;

  // one pattern memory entry
  typedef struct packed {
    logic       wild;
    logic [7:0] value;
  } wbps_pat_t;

endpackage

>>> rtl/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// APB register file holding pattern length and the two scan limits.
// ----------------------------------------------------------------------------
module wbps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wbps_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output wbps_pkg::wbps_cfg_t            cfg_o
);
  import wbps_pkg::*;

  wbps_cfg_t cfg_q;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length  <= PATTERN_LENGTH_RST;
      cfg_q.max_results     <= MAX_RESULTS_RST;
      cfg_q.max_byte_budget <= MAX_BUDGET_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PATTERN_LENGTH: cfg_q.pattern_length  <= pwdata[6:0];
        REG_MAX_RESULTS:    cfg_q.max_results     <= pwdata;
        REG_MAX_BUDGET:     cfg_q.max_byte_budget <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_PATTERN_LENGTH: prdata = {25'd0, cfg_q.pattern_length};
      REG_MAX_RESULTS:    prdata = cfg_q.max_results;
      REG_MAX_BUDGET:     prdata = cfg_q.max_byte_budget;
      default:            prdata = '0;
    endcase
  end

endmodule

>>> rtl/wbps_mem.sv
// ----------------------------------------------------------------------------
// wbps_mem
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module wbps_mem #(
  parameter  int unsigned DEPTH = wbps_pkg::PATTERN_MAX_DEF,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/wbps_ctrl.sv
// ----------------------------------------------------------------------------
// wbps_ctrl
// Command sequencer: loads pattern entries, keeps the byte window and the
// scan totals, and walks pattern and window memories one entry per cycle.
// ----------------------------------------------------------------------------
module wbps_ctrl #(
  parameter  int unsigned PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wbps_pkg::wbps_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  input  wbps_pkg::wbps_in_t    in_word_i,
  output logic                  in_stall_o,
  output logic                  res_valid_o,
  output wbps_pkg::wbps_out_t   res_word_o,
  input  logic                  res_free_i,
  output logic                  pat_we_o,
  output logic [AW-1:0]         pat_waddr_o,
  output wbps_pkg::wbps_pat_t   pat_wdata_o,
  output logic                  pat_re_o,
  output logic [AW-1:0]         pat_raddr_o,
  input  wbps_pkg::wbps_pat_t   pat_rdata_i,
  output logic                  win_we_o,
  output logic [AW-1:0]         win_waddr_o,
  output logic [7:0]            win_wdata_o,
  output logic                  win_re_o,
  output logic [AW-1:0]         win_raddr_o,
  input  logic [7:0]            win_rdata_i
);
  import wbps_pkg::*;

  localparam logic [1:0]    ST_IDLE  = 2'd0;
  localparam logic [1:0]    ST_SCAN  = 2'd1;
  localparam logic [1:0]    ST_DONE  = 2'd2;
  localparam logic [AW-1:0] LAST_POS = AW'(PATTERN_MAX - 1);
  localparam logic [LW-1:0] LEN_MAX  = LW'(PATTERN_MAX);

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [AW-1:0] wr_pos_q, wr_pos_d;
  logic [31:0]   offset_q, offset_d;
  logic [63:0]   base_q, base_d;
  logic [31:0]   found_q, found_d;
  logic [31:0]   consumed_q, consumed_d;
  logic          budget_hit_q, budget_hit_d;
  logic [LW-1:0] issue_q, issue_d;
  logic          pend_q, pend_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] pa_q, pa_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          mism_q, mism_d;
  wbps_out_t     res_q, res_d;

  logic          accept;
  logic [LW-1:0] len_act;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] wa_next;
  logic [LW-1:0] fill_next;
  logic [31:0]   start_sum;
  logic [31:0]   start_wrap;
  logic [31:0]   idx_ext;
  logic          issuing;
  logic          miss_now;
  logic          scan_end;
  logic          res_now_valid;
  wbps_out_t     res_now;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // clamp pattern length to one .. depth
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_act = LW'(1);
    end else if (32'(cfg_i.pattern_length) > PATTERN_MAX) begin
      len_act = LEN_MAX;
    end else begin
      len_act = LW'(cfg_i.pattern_length);
    end
  end

  // ring pointers and window start of the compare walk
  assign wp_next    = (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + AW'(1);
  assign wa_next    = (wa_q == LAST_POS) ? '0 : wa_q + AW'(1);
  assign fill_next  = (fill_q == LEN_MAX) ? fill_q : fill_q + LW'(1);
  assign start_sum  = 32'(wp_next) + PATTERN_MAX - 32'(len_act);
  assign start_wrap = (start_sum >= PATTERN_MAX) ? start_sum - PATTERN_MAX : start_sum;
  assign idx_ext    = 32'(in_word_i.entry_index);

  // compare walk
  assign issuing  = (state_q == ST_SCAN) && (issue_q != len_q);
  assign miss_now = pend_q && !pat_rdata_i.wild && (pat_rdata_i.value != win_rdata_i);
  assign scan_end = (state_q == ST_SCAN) && pend_q && (issue_q == len_q);

  // memory ports
  assign pat_waddr_o       = idx_ext[AW-1:0];
  assign pat_wdata_o.wild  = in_word_i.entry_wildcard;
  assign pat_wdata_o.value = in_word_i.entry_value;
  assign pat_re_o          = issuing;
  assign pat_raddr_o       = pa_q;
  assign win_waddr_o       = wr_pos_q;
  assign win_wdata_o       = in_word_i.data_byte;
  assign win_re_o          = issuing;
  assign win_raddr_o       = wa_q;

  // next state and result
  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    wr_pos_d      = wr_pos_q;
    offset_d      = offset_q;
    base_d        = base_q;
    found_d       = found_q;
    consumed_d    = consumed_q;
    budget_hit_d  = budget_hit_q;
    issue_d       = issue_q;
    pend_d        = pend_q;
    len_d         = len_q;
    pa_d          = pa_q;
    wa_d          = wa_q;
    mism_d        = mism_q;
    res_d         = res_q;
    res_now       = '0;
    res_now_valid = 1'b0;
    pat_we_o      = 1'b0;
    win_we_o      = 1'b0;

    if (accept) begin
      case (in_word_i.command)
        CMD_LOAD: begin
          pat_we_o       = (idx_ext < PATTERN_MAX);
          res_now_valid  = 1'b1;
          res_now.status = STAT_LOADED;
        end
        CMD_START: begin
          base_d   = in_word_i.range_base;
          fill_d   = '0;
          offset_d = '0;
          wr_pos_d = '0;
          if (in_word_i.new_scan) begin
            found_d      = '0;
            consumed_d   = '0;
            budget_hit_d = 1'b0;
          end
          res_now_valid  = 1'b1;
          res_now.status = STAT_STARTED;
        end
        CMD_DATA: begin
          if (consumed_q >= cfg_i.max_byte_budget) begin
            budget_hit_d = 1'b1;
          end
          if ((found_q >= cfg_i.max_results) ||
              (consumed_q >= cfg_i.max_byte_budget)) begin
            res_now_valid  = 1'b1;
            res_now.status = STAT_REFUSED;
          end else begin
            consumed_d = consumed_q + 32'd1;
            win_we_o   = 1'b1;
            wr_pos_d   = wp_next;
            fill_d     = fill_next;
            offset_d   = offset_q + 32'd1;
            if (fill_next >= len_act) begin
              state_d = ST_SCAN;
              len_d   = len_act;
              issue_d = '0;
              pend_d  = 1'b0;
              pa_d    = '0;
              wa_d    = start_wrap[AW-1:0];
              mism_d  = 1'b0;
            end else begin
              res_now_valid  = 1'b1;
              res_now.status = STAT_NOMATCH;
            end
          end
        end
        default: begin
          res_now_valid  = 1'b1;
          res_now.status = STAT_NOMATCH;
        end
      endcase
    end else if (state_q == ST_SCAN) begin
      pend_d = issuing;
      mism_d = mism_q | miss_now;
      if (issuing) begin
        issue_d = issue_q + LW'(1);
        pa_d    = pa_q + AW'(1);
        wa_d    = wa_next;
      end
      if (scan_end) begin
        res_now_valid = 1'b1;
        if (!(mism_q || miss_now)) begin
          found_d               = found_q + 32'd1;
          res_now.status        = STAT_MATCH;
          res_now.match_address = base_q + 64'(offset_q - 32'(len_q));
        end else begin
          res_now.status = STAT_NOMATCH;
        end
      end
    end

    // totals after the step
    res_now.match_count          = found_d;
    res_now.bytes_scanned        = consumed_d;
    res_now.result_limit_reached = (found_d >= cfg_i.max_results);
    res_now.byte_limit_reached   = budget_hit_d;

    // hand off to the output register or park the result
    if (res_now_valid) begin
      res_d   = res_now;
      state_d = res_free_i ? ST_IDLE : ST_DONE;
    end else if ((state_q == ST_DONE) && res_free_i) begin
      state_d = ST_IDLE;
    end
  end

  assign res_valid_o = res_now_valid || (state_q == ST_DONE);
  assign res_word_o  = (state_q == ST_DONE) ? res_q : res_now;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      wr_pos_q     <= '0;
      offset_q     <= '0;
      base_q       <= '0;
      found_q      <= '0;
      consumed_q   <= '0;
      budget_hit_q <= 1'b0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      wr_pos_q     <= wr_pos_d;
      offset_q     <= offset_d;
      base_q       <= base_d;
      found_q      <= found_d;
      consumed_q   <= consumed_d;
      budget_hit_q <= budget_hit_d;
      issue_q      <= issue_d;
      pend_q       <= pend_d;
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    pa_q   <= pa_d;
    wa_q   <= wa_d;
    mism_q <= mism_d;
    res_q  <= res_d;
  end

endmodule

>>> rtl/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Byte stream scanner that matches a loadable pattern with wildcard entries
// against the newest bytes of an address range.
//
//   channel  direction  handshake               word
//   in       input      in_valid_i / in_stall_o   wbps_in_t
//   out      output     out_valid_o / out_stall_i wbps_out_t
//   cfg      input      apb psel/penable/pready   pattern_length, limits
//
// Load, start, unused, refused and short-window words are answered without a walk.
// A data byte with a full window walks L entries, L being pattern_length
// clamped to 1 .. PATTERN_MAX: one pattern entry and window byte per cycle.
// Results are formed combinationally and leave through an output register.
// Reset empties the window and clears the totals; pattern entries are kept.
// A stalled output holds one word, one more result parks, then the input stalls.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int unsigned PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wbps_pkg::wbps_in_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wbps_pkg::wbps_out_t         out_word_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wbps_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wbps_pkg::*;

  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  wbps_cfg_t cfg;
  logic      res_valid;
  wbps_out_t res_word;
  logic      res_free;
  logic      out_valid_q;
  wbps_out_t out_word_q;

  logic          pat_we, pat_re;
  logic [AW-1:0] pat_waddr, pat_raddr;
  wbps_pat_t     pat_wdata, pat_rdata;
  logic          win_we, win_re;
  logic [AW-1:0] win_waddr, win_raddr;
  logic [7:0]    win_wdata, win_rdata;

  wbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pattern entries: wildcard mark and value
  wbps_mem #(
    .DEPTH (PATTERN_MAX),
    .WIDTH ($bits(wbps_pat_t))
  ) u_pat_mem (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .re_i    (pat_re),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // ring of recent data bytes
  wbps_mem #(
    .DEPTH (PATTERN_MAX),
    .WIDTH (8)
  ) u_win_mem (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  wbps_ctrl #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .res_free_i  (res_free),
    .pat_we_o    (pat_we),
    .pat_waddr_o (pat_waddr),
    .pat_wdata_o (pat_wdata),
    .pat_re_o    (pat_re),
    .pat_raddr_o (pat_raddr),
    .pat_rdata_i (pat_rdata),
    .win_we_o    (win_we),
    .win_waddr_o (win_waddr),
    .win_wdata_o (win_wdata),
    .win_re_o    (win_re),
    .win_raddr_o (win_raddr),
    .win_rdata_i (win_rdata)
  );

  // output register
  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbps_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  wbps_pkg::wbps_out_t         out_word_o,
  input  logic                        pready
);
  import wbps_pkg::*;

  // a stalled word stays put
  `WBPS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "out word changed while stalled")

  // a match always counts itself and the byte that closed it
  `WBPS_ASSERT(a_match_totals, out_valid_o && out_word_o.status == STAT_MATCH |-> out_word_o.match_count != '0 && out_word_o.bytes_scanned != '0, "match with zero totals")

  // address is only carried by a match
  `WBPS_ASSERT(a_addr_zero, out_valid_o && out_word_o.status != STAT_MATCH |-> out_word_o.match_address == '0, "address on a non-match word")

  // status stays within the defined codes
  `WBPS_ASSERT_ALL(a_status_code, out_valid_o |-> out_word_o.status <= STAT_REFUSED, "undefined status code")

  // register port never waits
  `WBPS_ASSERT_ALL(a_pready_high, pready, "pready dropped")

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
